// File: rtl/core/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// Types and constants shared by the sorted priority queue and its cells.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int DEFAULT_CAPACITY = 16;
  localparam int DATA_W           = 32;
  localparam int PRIO_W           = 16;
  localparam int OCC_W            = 5;

  localparam logic signed [DATA_W-1:0] EMPTY_DATA = '1;

  typedef enum logic {
    ACT_ENQ = 1'b0,
    ACT_DEQ = 1'b1
  } action_t;

  typedef struct packed {
    action_t                   action;
    logic signed [DATA_W-1:0]  data_in;
    logic        [PRIO_W-1:0]  prio_in;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0]  data_out;
    logic                      data_valid;
    logic                      was_empty;
    logic                      rejected_full;
    logic        [OCC_W-1:0]   occupancy;
  } out_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0]  data;
    logic        [PRIO_W-1:0]  prio;
  } entry_t;

  typedef struct packed {
    logic   enq;
    logic   deq;
    entry_t ent;
  } cell_cmd_t;

endpackage

// File: rtl/core/spq_cell.sv
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted chain: holds an entry, keeps it, takes the new
// entry or shifts in from a neighbor.
// ----------------------------------------------------------------------------
module spq_cell import spq_pkg::*; (
  input  logic      clk,
  input  cell_cmd_t cmd,
  input  logic      occupied,
  input  logic      left_keep,
  input  entry_t    left_ent,
  input  entry_t    right_ent,
  output logic      keep,
  output entry_t    ent
);

  entry_t ent_r;
  entry_t ent_nxt;

  assign keep = occupied && (ent_r.prio >= cmd.ent.prio);
  assign ent  = ent_r;

  always_comb begin
    ent_nxt = ent_r;
    if (cmd.enq && !keep) begin
      ent_nxt = left_keep ? cmd.ent : left_ent;
    end else if (cmd.deq) begin
      ent_nxt = right_ent;
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

endmodule

// File: rtl/core/sorted_priority_queue.sv
// the result of an accepted transaction is registered straight into the output register
// throughput: one enqueue or dequeue per cycle while in_stall is low; every cell updates in parallel
// each transaction gives exactly one result; output register lets input proceed
// reset: synchronous active-low clears the fill count and output valid
// entry cells are not reset; slots beyond the fill count are never read
// ----------------------------------------------------------------------------
// sorted_priority_queue
// Priority queue kept sorted in a chain of cells, highest priority at head.
// ----------------------------------------------------------------------------
module sorted_priority_queue import spq_pkg::*; #(
  parameter int CAPACITY = DEFAULT_CAPACITY
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  localparam int CW = $clog2(CAPACITY + 1);

  logic [CW-1:0]        count_r;
  logic [CW-1:0]        count_nxt;
  logic                 out_valid_r;
  logic                 out_valid_nxt;
  out_item_t            out_item_r;
  out_item_t            out_item_nxt;
  logic                 in_acc;
  logic                 full;
  logic                 empty;
  logic                 is_deq;
  cell_cmd_t            cmd;
  logic [CAPACITY-1:0]  occ;
  logic [CAPACITY-1:0]  keep;
  entry_t               ents [CAPACITY];
  logic [CW+OCC_W-1:0]  occ_ext;

  assign in_stall  = out_valid_r && out_stall;
  assign in_acc    = in_valid && !in_stall;
  assign full      = (count_r == CW'(CAPACITY));
  assign empty     = (count_r == '0);
  assign is_deq    = (in_item.action == ACT_DEQ);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  assign cmd.enq      = in_acc && !is_deq && !full;
  assign cmd.deq      = in_acc && is_deq && !empty;
  assign cmd.ent.data = in_item.data_in;
  assign cmd.ent.prio = in_item.prio_in;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    entry_t left_ent;
    entry_t right_ent;
    logic   left_keep;

    assign occ[g] = (count_r > CW'(g));

    if (g == 0) begin : g_head
      assign left_keep = 1'b1;
      assign left_ent  = cmd.ent;
    end else begin : g_mid
      assign left_keep = keep[g-1];
      assign left_ent  = ents[g-1];
    end

    if (g == CAPACITY - 1) begin : g_tail
      assign right_ent = ents[g];
    end else begin : g_body
      assign right_ent = ents[g+1];
    end

    spq_cell u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .occupied  (occ[g]),
      .left_keep (left_keep),
      .left_ent  (left_ent),
      .right_ent (right_ent),
      .keep      (keep[g]),
      .ent       (ents[g])
    );
  end

  always_comb begin
    count_nxt = count_r;
    if (cmd.enq) begin
      count_nxt = count_r + CW'(1);
    end else if (cmd.deq) begin
      count_nxt = count_r - CW'(1);
    end
  end

  assign occ_ext = {{OCC_W{1'b0}}, count_nxt};

  always_comb begin
    out_item_nxt               = out_item_r;
    out_valid_nxt              = out_valid_r && out_stall;
    if (in_acc) begin
      out_valid_nxt              = 1'b1;
      out_item_nxt.data_out      = '0;
      out_item_nxt.data_valid    = cmd.deq;
      out_item_nxt.was_empty     = is_deq && empty;
      out_item_nxt.rejected_full = !is_deq && full;
      out_item_nxt.occupancy     = occ_ext[OCC_W-1:0];
      if (is_deq) begin
        out_item_nxt.data_out = empty ? EMPTY_DATA : ents[0].data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_item_r <= out_item_nxt;
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("fill count exceeds capacity");

  a_enq_grows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.enq |=> count_r == $past(count_r) + CW'(1))
    else $error("enqueue did not grow the queue");

  a_deq_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.deq |=> count_r == $past(count_r) - CW'(1))
    else $error("dequeue did not shrink the queue");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> out_valid_r)
    else $error("accepted transaction gave no result");

  a_head_sorted: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r >= CW'(2)) |-> (ents[0].prio >= ents[1].prio))
    else $error("head entries out of order");
`endif

endmodule

// File: test/spq_checker.sv
// ----------------------------------------------------------------------------
// spq_checker
// Watches both channels of the sorted priority queue. Every accepted input
// transaction updates a sorted shadow store and queues the result it should
// give. Every accepted result is compared field by field against the oldest
// queued result. Reports the failure count and the results still owed.
// ----------------------------------------------------------------------------
module spq_checker import spq_pkg::*; #(
  parameter int CAPACITY = DEFAULT_CAPACITY
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_stall,
  input  in_item_t  in_item,
  input  logic      out_valid,
  input  logic      out_stall,
  input  out_item_t out_item,
  output int        fail_count,
  output int        pending
);

  entry_t    held_entries[$];
  out_item_t expected_results[$];

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  function automatic out_item_t serve_transaction(in_item_t it);
    out_item_t res;
    entry_t    ent;
    int        pos;
    res = '0;
    if (it.action == ACT_ENQ) begin
      if (held_entries.size() >= CAPACITY) begin
        res.rejected_full = 1'b1;
      end else begin
        pos = 0;
        while (pos < held_entries.size() && held_entries[pos].prio >= it.prio_in) pos++;
        ent.data = it.data_in;
        ent.prio = it.prio_in;
        held_entries.insert(pos, ent);
      end
    end else begin
      if (held_entries.size() == 0) begin
        res.data_out  = EMPTY_DATA;
        res.was_empty = 1'b1;
      end else begin
        ent            = held_entries.pop_front();
        res.data_out   = ent.data;
        res.data_valid = 1'b1;
      end
    end
    res.occupancy = OCC_W'(held_entries.size());
    return res;
  endfunction

  function automatic void compare_field(string name, logic [DATA_W-1:0] want,
                                        logic [DATA_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin : monitor
    out_item_t want;
    if (!rst_n) begin
      held_entries.delete();
      expected_results.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected transaction, expected none, got %h", $time, out_item);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          compare_field("data_out", want.data_out, out_item.data_out);
          compare_field("data_valid", DATA_W'(want.data_valid),
                        DATA_W'(out_item.data_valid));
          compare_field("was_empty", DATA_W'(want.was_empty),
                        DATA_W'(out_item.was_empty));
          compare_field("rejected_full", DATA_W'(want.rejected_full),
                        DATA_W'(out_item.rejected_full));
          compare_field("occupancy", DATA_W'(want.occupancy),
                        DATA_W'(out_item.occupancy));
        end
      end
      if (in_valid && !in_stall) expected_results.push_back(serve_transaction(in_item));
    end
    pending <= expected_results.size();
  end

endmodule

// File: test/tb_sorted_priority_queue.sv
// ----------------------------------------------------------------------------
// tb_sorted_priority_queue
// Drives enqueue and dequeue transactions into the sorted priority queue with
// random gaps and random output stalls. A directed opening covers empty
// dequeue, fill to capacity, rejected enqueue, equal priorities and extreme
// values; random phases then vary the enqueue mix and priority spread.
// ----------------------------------------------------------------------------
module tb_sorted_priority_queue;
  import spq_pkg::*;

  localparam int CAPACITY      = DEFAULT_CAPACITY;
  localparam int RANDOM_ITEMS  = 750;
  localparam int SETTLE_CYCLES = 8;
  localparam int RUN_LIMIT     = 400000;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_item   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;
  int        fail_count;
  int        pending;
  bit        tx_idle   = 1'b1;
  bit        rx_idle   = 1'b1;
  int unsigned stall_left = 0;

  sorted_priority_queue #(.CAPACITY(CAPACITY)) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  spq_checker #(.CAPACITY(CAPACITY)) result_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_item   (out_item),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin : receiver
    int unsigned n;
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= (stall_left != 1);
    end else if (out_valid && !out_stall) begin
      n = rx_idle ? $urandom_range(0, 8) : 0;
      stall_left <= n;
      out_stall  <= (n != 0);
    end
  end

  function automatic in_item_t enq_item(logic [DATA_W-1:0] d, logic [PRIO_W-1:0] p);
    in_item_t it;
    it.action  = ACT_ENQ;
    it.data_in = d;
    it.prio_in = p;
    return it;
  endfunction

  function automatic in_item_t deq_item();
    in_item_t it;
    it.action  = ACT_DEQ;
    it.data_in = $urandom;
    it.prio_in = PRIO_W'($urandom);
    return it;
  endfunction

  function automatic logic [PRIO_W-1:0] pick_prio(int mode);
    case (mode)
      0:       return PRIO_W'($urandom_range(0, 3));
      1:       return PRIO_W'($urandom);
      default: return $urandom_range(0, 1) ? {PRIO_W{1'b1}} : '0;
    endcase
  endfunction

  task automatic send(input in_item_t it);
    int unsigned gap;
    gap = tx_idle ? $urandom_range(0, 8) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (in_stall);
  endtask

  // hold off until every owed result has been accepted
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  initial begin : stimulus
    logic [PRIO_W-1:0] dir_prio [10];
    logic [DATA_W-1:0] d;
    logic [PRIO_W-1:0] p;
    int sent;
    int phase;
    int phase_len;
    int enq_pct;
    int prio_mode;
    dir_prio = '{16'hFFFF, 16'h0000, 16'h0005, 16'h0005, 16'h8000,
                 16'h0005, 16'h0001, 16'hFFFF, 16'h7FFF, 16'h0000};
    sent  = 0;
    phase = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    send(deq_item());
    for (int i = 0; i < CAPACITY; i++) begin
      case (i)
        0:       d = 32'h7FFF_FFFF;
        1:       d = 32'h8000_0000;
        2:       d = '0;
        3:       d = '1;
        default: d = $urandom;
      endcase
      p = (i < 10) ? dir_prio[i] : PRIO_W'($urandom_range(0, 7));
      send(enq_item(d, p));
    end
    send(enq_item($urandom, PRIO_W'($urandom)));
    repeat (3) send(deq_item());
    drain();

    while (sent < RANDOM_ITEMS) begin
      enq_pct   = 20 + 30 * $urandom_range(0, 2);
      prio_mode = $urandom_range(0, 2);
      tx_idle   = ($urandom_range(0, 3) != 0);
      rx_idle   = ($urandom_range(0, 3) != 0);
      phase_len = $urandom_range(30, 70);
      repeat (phase_len) begin
        if ($urandom_range(1, 100) <= enq_pct) send(enq_item($urandom, pick_prio(prio_mode)));
        else send(deq_item());
        sent++;
      end
      if (phase % 3 == 2) drain();
      phase++;
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("sorted_priority_queue test passed");
    end else begin
      $display("sorted_priority_queue test failed");
    end
    $finish;
  end

  initial begin
    #(RUN_LIMIT);
    $display("sorted_priority_queue test failed");
    $finish;
  end

endmodule
